>>> hdl/atcl_pkg.sv
// atcl_pkg: shared types, constants and the command pattern table
`timescale 1ns / 1ps

package atcl_pkg;

	// sizes and codes
	localparam int LINE_MAX_DEF = 64;
	localparam int PAT_NUM      = 20;
	localparam int PAT_LEN_MAX  = 11;
	localparam int PAT_POS_W    = 4;
	localparam int CODE_W       = 5;

	// command codes as reported on every result of a line
	typedef enum logic [CODE_W-1:0] {
		CMD_CKPD,
		CMD_VGM,
		CMD_VGS,
		CMD_BRSF,
		CMD_CIND_READ,
		CMD_CIND_TEST,
		CMD_CMER,
		CMD_ANSWER,
		CMD_HANGUP,
		CMD_DIAL_MEM,
		CMD_DIAL,
		CMD_REDIAL,
		CMD_CCWA,
		CMD_CLIP,
		CMD_VTS,
		CMD_CHLD,
		CMD_BVRA,
		CMD_OK,
		CMD_ERROR,
		CMD_UNKNOWN
	} cmd_code_t;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// patterns padded to full width, first character in the top byte
	localparam logic [PAT_LEN_MAX*8-1:0] PAT_TEXT [PAT_NUM] = '{
		"AT+CKPD=200",
		"AT+VGM=    ",
		"AT+VGS=    ",
		"AT+BRSF=   ",
		"AT+CIND?   ",
		"AT+CIND=?  ",
		"AT+CMER=   ",
		"ATA        ",
		"AT+CHUP    ",
		"ATD>       ",
		"ATD        ",
		"AT+BLDN    ",
		"AT+CCWA=   ",
		"AT+CLIP=   ",
		"AT+VTS=    ",
		"AT+CHLD=   ",
		"AT+BVRA=   ",
		"ATH        ",
		"\015\012OK       ",
		"\015\012ERROR    "
	};

	localparam logic [PAT_POS_W-1:0] PAT_LEN [PAT_NUM] = '{
		4'd11, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd8, 4'd3, 4'd7, 4'd4,
		4'd3, 4'd7, 4'd8, 4'd8, 4'd7, 4'd8, 4'd8, 4'd3, 4'd4, 4'd7
	};

	localparam logic [CODE_W-1:0] PAT_CODE [PAT_NUM] = '{
		CMD_CKPD, CMD_VGM, CMD_VGS, CMD_BRSF, CMD_CIND_READ, CMD_CIND_TEST,
		CMD_CMER, CMD_ANSWER, CMD_HANGUP, CMD_DIAL_MEM, CMD_DIAL, CMD_REDIAL,
		CMD_CCWA, CMD_CLIP, CMD_VTS, CMD_CHLD, CMD_BVRA, CMD_HANGUP,
		CMD_OK, CMD_ERROR
	};

	// replies must match the whole line, commands only its start
	localparam logic [PAT_NUM-1:0] PAT_EXACT = 20'b1100_0000_0000_0000_0000;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMD,
		ST_PARAM
	} state_t;

	// matcher control from the sequencer
	typedef struct packed {
		logic                 clr;
		logic                 upd;
		logic [PAT_POS_W-1:0] pos;
		logic [7:0]           data;
	} match_ctl_t;

	// classification of the held line
	typedef struct packed {
		logic [CODE_W-1:0]    code;
		logic                 prefix;
		logic [PAT_POS_W-1:0] plen;
	} match_res_t;

	// ascii upper-case fold
	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

	// character p of pattern i
	function automatic logic [7:0] pat_char(input int unsigned i,
			input logic [PAT_POS_W-1:0] p);
		logic [7:0] r;
		r = 8'h00;
		if (int'(p) < PAT_LEN_MAX) begin
			r = PAT_TEXT[i][(PAT_LEN_MAX-1-int'(p))*8 +: 8];
		end
		return r;
	endfunction

endpackage

>>> hdl/at_command_line_classifier_top.sv
// at_command_line_classifier_top: line collection, sequencing and result register
`timescale 1ns / 1ps
//
//  channel  signals                                         direction
//  input    in_valid, in_ready, rx_byte                     byte in
//  output   out_valid, out_ready, command, param_byte,      result out
//           param_valid, overflow, last
//
//  A byte that does not end a line is taken while idle, and input stays ready for the next byte.
//  A terminating carriage return starts emission: the command result first, then one result
//  per parameter byte read from the line buffer port, each held while the output stalls.
//  No input is taken while a line is being emitted; the last result may still be waiting.
//  Reset clears line length, overflow, line feed drop and the sequencer; the buffer is not
//  cleared, entries are only read after being written.

module at_command_line_classifier_top
	import atcl_pkg::*;
#(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CODE_W-1:0] command,
	output logic [7:0]        param_byte,
	output logic              param_valid,
	output logic              overflow,
	output logic              last
);

	localparam int LEN_W = $clog2(LINE_MAX + 1);
	localparam int AW    = $clog2(LINE_MAX);

	state_t state_q, state_d;

	logic [LEN_W-1:0]  len_q;
	logic              ovf_q;
	logic              drop_q;
	logic [CODE_W-1:0] code_q;
	logic              lovf_q;
	logic [LEN_W-1:0]  start_q;
	logic [LEN_W-1:0]  end_q;
	logic [LEN_W-1:0]  idx_q;

	logic              out_valid_q;
	logic [CODE_W-1:0] command_q;
	logic [7:0]        param_byte_q;
	logic              param_valid_q;
	logic              overflow_q;
	logic              last_q;

	logic             in_xfer;
	logic             lf_drop;
	logic             line_end;
	logic             store;
	logic             out_free;
	logic             ld_cmd;
	logic             ld_param;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [7:0]       rd_data;
	logic [LEN_W-1:0] idx_nx;
	logic             par_last;
	match_ctl_t       mctl;
	match_res_t       mres;

	// input transfer decode
	assign in_xfer  = in_valid && in_ready;
	assign lf_drop  = drop_q && (rx_byte == CH_LF);
	assign line_end = !lf_drop && (rx_byte == CH_CR) && (len_q != '0);
	assign store    = in_xfer && !lf_drop && !line_end && (len_q < LEN_W'(LINE_MAX));
	assign out_free = !out_valid_q || out_ready;
	assign idx_nx   = idx_q + LEN_W'(1);
	assign par_last = (idx_nx == end_q);

	// matcher control
	always_comb begin
		mctl.clr  = in_xfer && line_end;
		mctl.upd  = store && (len_q < LEN_W'(PAT_LEN_MAX));
		mctl.pos  = len_q[PAT_POS_W-1:0];
		mctl.data = rx_byte;
	end

	atcl_line_ram #(
		.DEPTH (LINE_MAX),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (store),
		.waddr (len_q[AW-1:0]),
		.wdata (rx_byte),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	atcl_matcher #(
		.LEN_W (LEN_W)
	) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mctl),
		.line_len (len_q),
		.res      (mres)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer && line_end) begin
					state_d = ST_CMD;
				end
			end
			ST_CMD: begin
				if (out_free) begin
					state_d = (start_q == end_q) ? ST_IDLE : ST_PARAM;
				end
			end
			ST_PARAM: begin
				if (out_free && par_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		ld_cmd   = 1'b0;
		ld_param = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = start_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_CMD: begin
				ld_cmd = out_free;
				rd_en  = out_free && (start_q != end_q);
			end
			ST_PARAM: begin
				ld_param = out_free;
				rd_en    = out_free && !par_last;
				rd_addr  = idx_nx[AW-1:0];
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// line control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			ovf_q  <= 1'b0;
			drop_q <= 1'b0;
		end else if (in_xfer) begin
			drop_q <= 1'b0;
			if (line_end) begin
				len_q  <= '0;
				ovf_q  <= 1'b0;
				drop_q <= 1'b1;
			end else if (!lf_drop) begin
				if (len_q < LEN_W'(LINE_MAX)) begin
					len_q <= len_q + LEN_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// captured line summary for emission
	always_ff @(posedge clk) begin
		if (in_xfer && line_end) begin
			code_q  <= mres.code;
			lovf_q  <= ovf_q;
			end_q   <= len_q;
			start_q <= mres.prefix ? LEN_W'(mres.plen) : len_q;
		end
	end

	// read index
	always_ff @(posedge clk) begin
		if (ld_cmd) begin
			idx_q <= start_q;
		end else if (rd_en) begin
			idx_q <= idx_nx;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_cmd || ld_param) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ld_cmd) begin
			command_q     <= code_q;
			param_byte_q  <= 8'h00;
			param_valid_q <= 1'b0;
			overflow_q    <= lovf_q;
			last_q        <= (start_q == end_q);
		end else if (ld_param) begin
			command_q     <= code_q;
			param_byte_q  <= rd_data;
			param_valid_q <= 1'b1;
			overflow_q    <= lovf_q;
			last_q        <= par_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign command     = command_q;
	assign param_byte  = param_byte_q;
	assign param_valid = param_valid_q;
	assign overflow    = overflow_q;
	assign last        = last_q;

endmodule

>>> hdl/atcl_line_ram.sv
// atcl_line_ram: line buffer, one write port and one registered read port
`timescale 1ns / 1ps

module atcl_line_ram
	import atcl_pkg::*;
#(
	parameter int DEPTH = LINE_MAX_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/atcl_matcher.sv
// atcl_matcher: running per-pattern match flags and table-order classification
`timescale 1ns / 1ps

module atcl_matcher
	import atcl_pkg::*;
#(
	parameter int LEN_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  match_ctl_t       ctl,
	input  logic [LEN_W-1:0] line_len,
	output match_res_t       res
);

	logic [PAT_NUM-1:0] match_q;
	logic [PAT_NUM-1:0] hit;

	// flags narrow as each stored byte is compared at its position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '1;
		end else if (ctl.clr) begin
			match_q <= '1;
		end else if (ctl.upd) begin
			for (int i = 0; i < PAT_NUM; i++) begin
				if (ctl.pos < PAT_LEN[i] &&
						fold(ctl.data) != pat_char(i, ctl.pos)) begin
					match_q[i] <= 1'b0;
				end
			end
		end
	end

	// length check per pattern
	always_comb begin
		for (int i = 0; i < PAT_NUM; i++) begin
			if (PAT_EXACT[i]) begin
				hit[i] = match_q[i] && (line_len == LEN_W'(PAT_LEN[i]));
			end else begin
				hit[i] = match_q[i] && (line_len >= LEN_W'(PAT_LEN[i]));
			end
		end
	end

	// first hit in table order wins
	always_comb begin
		res.code   = CMD_UNKNOWN;
		res.prefix = 1'b0;
		res.plen   = '0;
		for (int i = PAT_NUM - 1; i >= 0; i--) begin
			if (hit[i]) begin
				res.code   = PAT_CODE[i];
				res.prefix = !PAT_EXACT[i];
				res.plen   = PAT_LEN[i];
			end
		end
	end

endmodule

>>> bench/at_command_line_classifier_top_tb.sv
// at_command_line_classifier_top_tb: self-checking bench with a line predictor and result scoreboard
`timescale 1ns / 1ps

module at_command_line_classifier_top_tb
	import atcl_pkg::*;
();

	typedef struct packed {
		logic [CODE_W-1:0] command;
		logic [7:0]        param_byte;
		logic              param_valid;
		logic              overflow;
		logic              last;
	} line_result_t;

	typedef struct {
		string     text;
		bit        typed;
		cmd_code_t code;
	} script_row_t;

	localparam int NUM_PREFIX = 18;
	localparam string REPLY_OK    = "\015\012OK";
	localparam string REPLY_ERROR = "\015\012ERROR";

	// prefix table in match order
	string cmd_text [NUM_PREFIX] = '{
		"AT+CKPD=200", "AT+VGM=", "AT+VGS=", "AT+BRSF=", "AT+CIND?", "AT+CIND=?",
		"AT+CMER=", "ATA", "AT+CHUP", "ATD>", "ATD", "AT+BLDN", "AT+CCWA=",
		"AT+CLIP=", "AT+VTS=", "AT+CHLD=", "AT+BVRA=", "ATH"
	};
	cmd_code_t cmd_code [NUM_PREFIX] = '{
		CMD_CKPD, CMD_VGM, CMD_VGS, CMD_BRSF, CMD_CIND_READ, CMD_CIND_TEST,
		CMD_CMER, CMD_ANSWER, CMD_HANGUP, CMD_DIAL_MEM, CMD_DIAL, CMD_REDIAL,
		CMD_CCWA, CMD_CLIP, CMD_VTS, CMD_CHLD, CMD_BVRA, CMD_HANGUP
	};

	// directed lines; typed rows carry a single command result
	script_row_t script [13] = '{
		'{"\015\012OK\015\012",    1'b1, CMD_OK},
		'{"\015\012ERROR\015\012", 1'b1, CMD_ERROR},
		'{"\015\012ok\015",        1'b1, CMD_OK},
		'{"\015\012OKX\015",       1'b1, CMD_UNKNOWN},
		'{"ath\015",               1'b1, CMD_HANGUP},
		'{"AT+CHUP\015\012",       1'b1, CMD_HANGUP},
		'{"AT\015",                1'b1, CMD_UNKNOWN},
		'{"\015ATA\015",           1'b1, CMD_UNKNOWN},
		'{"\015\015",              1'b1, CMD_UNKNOWN},
		'{"AT+CKPD=200\015",       1'b1, CMD_CKPD},
		'{"atd>3\015",             1'b0, CMD_UNKNOWN},
		'{"ATD12;\015",            1'b0, CMD_UNKNOWN},
		'{"X\015\012\012Y\015",    1'b0, CMD_UNKNOWN}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        rx_byte = 8'h00;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CODE_W-1:0] command;
	logic [7:0]        param_byte;
	logic              param_valid;
	logic              overflow;
	logic              last;

	// predictor state
	logic [7:0]   held [LINE_MAX_DEF];
	int unsigned  held_len = 0;
	bit           lf_pending = 1'b0;
	bit           held_ovf = 1'b0;

	line_result_t fresh [$];
	line_result_t expected_q [$];
	logic [7:0]   line_q [$];
	int           mismatches = 0;
	int unsigned  send_idle = 13;
	int unsigned  recv_idle = 76;

	at_command_line_classifier_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.command     (command),
		.param_byte  (param_byte),
		.param_valid (param_valid),
		.overflow    (overflow),
		.last        (last)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'h20 : c;
	endfunction

	function automatic bit held_starts_with(input string pat);
		if (held_len < pat.len()) return 1'b0;
		for (int j = 0; j < pat.len(); j++) begin
			if (upcase(held[j]) != upcase(pat[j])) return 1'b0;
		end
		return 1'b1;
	endfunction

	// advance the line predictor by one accepted byte, results land in fresh
	function automatic void predict_byte(input logic [7:0] b);
		cmd_code_t   code;
		int unsigned start;
		fresh = {};
		if (lf_pending) begin
			lf_pending = 1'b0;
			if (b == CH_LF) return;
		end
		if (b == CH_CR && held_len > 0) begin
			code = CMD_UNKNOWN;
			start = held_len;
			for (int i = 0; i < NUM_PREFIX; i++) begin
				if (held_starts_with(cmd_text[i])) begin
					code = cmd_code[i];
					start = cmd_text[i].len();
					break;
				end
			end
			if (code == CMD_UNKNOWN) begin
				if (held_len == 4 && held_starts_with(REPLY_OK)) code = CMD_OK;
				else if (held_len == 7 && held_starts_with(REPLY_ERROR)) code = CMD_ERROR;
			end
			fresh.push_back(line_result_t'{code, 8'h00, 1'b0, held_ovf, start == held_len});
			for (int unsigned i = start; i < held_len; i++) begin
				fresh.push_back(line_result_t'{code, held[i], 1'b1, held_ovf,
					i + 1 == held_len});
			end
			held_len = 0;
			held_ovf = 1'b0;
			lf_pending = 1'b1;
		end else if (held_len < LINE_MAX_DEF) begin
			held[held_len] = b;
			held_len++;
		end else begin
			held_ovf = 1'b1;
		end
	endfunction

	// append text to the pending line, optionally with random letter case
	task automatic push_text(input string s, input bit mix_case);
		logic [7:0] c;
		for (int j = 0; j < s.len(); j++) begin
			c = s[j];
			if (mix_case && c >= "A" && c <= "Z" && $urandom_range(1) == 1) c = c + 8'h20;
			line_q.push_back(c);
		end
	endtask

	// one byte transfer on the input channel, then record what it should cause
	task automatic send_byte(input logic [7:0] b, input bit typed, input cmd_code_t code);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		predict_byte(b);
		if (typed && fresh.size() != 0) begin
			expected_q.push_back(line_result_t'{code, 8'h00, 1'b0, 1'b0, 1'b1});
		end else begin
			foreach (fresh[k]) expected_q.push_back(fresh[k]);
		end
		@(negedge clk);
	endtask

	task automatic send_line(input bit typed, input cmd_code_t code);
		foreach (line_q[k]) send_byte(line_q[k], typed, code);
		line_q = {};
	endtask

	// hold the sender off until every pending result has arrived
	task automatic wait_all_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (expected_q.size() != 0);
	endtask

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		line_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result: command %0d param_byte %0h", command, param_byte);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				if (command !== want.command) begin
					$error("command: expected %0d actual %0d", want.command, command);
					mismatches++;
				end
				if (param_byte !== want.param_byte) begin
					$error("param_byte: expected %0h actual %0h", want.param_byte, param_byte);
					mismatches++;
				end
				if (param_valid !== want.param_valid) begin
					$error("param_valid: expected %0b actual %0b", want.param_valid, param_valid);
					mismatches++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %0b actual %0b", want.overflow, overflow);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b actual %0b", want.last, last);
					mismatches++;
				end
			end
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int unsigned kind;
		int unsigned count;
		int unsigned sent;
		logic [7:0]  c;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed lines
		foreach (script[r]) begin
			push_text(script[r].text, 1'b0);
			send_line(script[r].typed, script[r].code);
		end

		// a zero byte at line start, then an overflowed line with byte extremes
		line_q.push_back(8'h00);
		line_q.push_back(CH_CR);
		push_text("AT+VGM=", 1'b0);
		line_q.push_back(8'h00);
		line_q.push_back(8'hFF);
		line_q.push_back(8'h80);
		for (int j = 0; j < 55; j++) line_q.push_back(8'("0" + j % 10));
		line_q.push_back(CH_CR);
		send_line(1'b0, CMD_UNKNOWN);

		// random lines over three idle profiles
		for (int phase = 0; phase < 3; phase++) begin
			wait_all_results();
			send_idle = (phase == 0) ? 13 : (phase == 1) ? 76 : 0;
			recv_idle = (phase == 0) ? 76 : (phase == 1) ? 13 : 0;
			sent = 0;
			while (sent < 6) begin
				kind = $urandom_range(99);
				if (kind < 62) begin
					// well-formed command with random parameter
					push_text(cmd_text[$urandom_range(NUM_PREFIX - 1)], 1'b1);
					count = $urandom_range(6);
					repeat (count) begin
						c = 8'($urandom_range(255));
						line_q.push_back(c == CH_CR ? 8'h20 : c);
					end
					line_q.push_back(CH_CR);
					if ($urandom_range(1) == 1) line_q.push_back(CH_LF);
				end else if (kind < 74) begin
					// reply framed by carriage return and line feed
					push_text(($urandom_range(1) == 1) ? REPLY_OK : REPLY_ERROR, 1'b1);
					line_q.push_back(CH_CR);
					line_q.push_back(CH_LF);
				end else begin
					// raw noise, may split or merge lines
					count = $urandom_range(1, 8);
					repeat (count) line_q.push_back(8'($urandom_range(255)));
				end
				sent += line_q.size();
				send_line(1'b0, CMD_UNKNOWN);
			end
		end

		wait_all_results();
		repeat (16) @(negedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
